// ===== rtl/core/sws_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the sliding window statistics block.
// No dependencies.
package sws_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int CFG_WIDTH    = 16;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [SAMPLE_WIDTH:0]          key_t;

  // cell operations
  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_ROTATE = 2'd2;
  localparam logic [1:0] OP_SORT   = 2'd3;

  // register indexes
  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic REG_STREAM_LENGTH = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_LONG_WINDOW = 2'd1;
  localparam logic [1:0] ST_ONE         = 2'd2;
  localparam logic [1:0] ST_ZERO        = 2'd3;

  typedef struct packed {
    logic       push;
    logic [1:0] op;
    logic       phase;
  } sws_ctl_t;

endpackage

// ===== rtl/core/sws_cell.sv =====
`timescale 1ns / 1ps
// One window cell: a stored sample and a work key for scan, sort and rotate.
// Depends on sws_pkg.
module sws_cell #(
  parameter int IDX = 0,
  parameter int N   = 32,
  parameter int CW  = 6
) (
  input  logic                     clk,
  input  sws_pkg::sws_ctl_t        ctl,
  input  logic [CW-1:0]            win_len,
  input  logic [CW-1:0]            real_len,
  input  sws_pkg::sample_t         first_sample,
  input  sws_pkg::sample_t         store_in,
  output sws_pkg::sample_t         store_out,
  input  sws_pkg::key_t            key_left,
  input  sws_pkg::key_t            key_right,
  output sws_pkg::key_t            key_out
);
  import sws_pkg::*;

  localparam logic PAR      = 1'((IDX % 2) == 1);
  localparam logic HAS_RGT  = (IDX < N - 1);
  localparam logic HAS_LFT  = (IDX > 0);

  sample_t store_r;
  key_t    key_r, key_nxt;
  logic    low, high;

  assign store_out = store_r;
  assign key_out   = key_r;
  assign low  = HAS_RGT && (ctl.phase == PAR);
  assign high = HAS_LFT && (ctl.phase != PAR);

  always_comb begin
    key_nxt = key_r;
    case (ctl.op)
      OP_LOAD: begin
        if (CW'(IDX) < real_len) begin
          key_nxt = {1'b0, ~store_r[SAMPLE_WIDTH-1], store_r[SAMPLE_WIDTH-2:0]};
        end else if (CW'(IDX) < win_len) begin
          key_nxt = {1'b0, ~first_sample[SAMPLE_WIDTH-1], first_sample[SAMPLE_WIDTH-2:0]};
        end else begin
          key_nxt = {1'b1, {SAMPLE_WIDTH{1'b0}}};
        end
      end
      OP_ROTATE: key_nxt = key_right;
      OP_SORT: begin
        if (low) begin
          key_nxt = (key_right < key_r) ? key_right : key_r;
        end else if (high) begin
          key_nxt = (key_left > key_r) ? key_left : key_r;
        end
      end
      default: key_nxt = key_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      store_r <= store_in;
    end
    key_r <= key_nxt;
  end

endmodule

// ===== rtl/core/sws_div.sv =====
`timescale 1ns / 1ps
// Iterative restoring unsigned divider, one quotient bit per cycle.
// No dependencies beyond sws_pkg.
module sws_div #(
  parameter int NW = 44,
  parameter int DW = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot
);
  import sws_pkg::*;

  localparam int CW = $clog2(NW + 1);

  logic          busy_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] rem_r, den_r;
  logic [NW-1:0] quo_r;
  logic [DW:0]   trial, diff;
  logic          ge;

  assign trial = {rem_r, quo_r[NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};
  assign done  = done_r;
  assign quot  = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_r <= {quo_r[NW-2:0], ge};
    end
  end

endmodule

// ===== rtl/core/sws_sqrt.sv =====
`timescale 1ns / 1ps
// Iterative floor square root, one root bit per cycle.
// No dependencies beyond sws_pkg.
module sws_sqrt #(
  parameter int RW = 44
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [RW-1:0]   rad,
  output logic            done,
  output logic [RW/2-1:0] root
);
  import sws_pkg::*;

  localparam int HW = RW / 2;
  localparam int CW = $clog2(HW + 1);

  logic          busy_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [RW-1:0] rad_r;
  logic [HW-1:0] root_r;
  logic [HW:0]   rem_r;
  logic [HW+2:0] rem_t, trial, diff;
  logic          ge;

  assign rem_t = {rem_r, rad_r[RW-1:RW-2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign diff  = rem_t - trial;
  assign ge    = rem_t >= trial;
  assign done  = done_r;
  assign root  = root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(HW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      root_r <= '0;
      rem_r  <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RW-3:0], 2'b00};
      rem_r  <= ge ? diff[HW:0] : rem_t[HW:0];
      root_r <= {root_r[HW-2:0], ge};
    end
  end

endmodule

// ===== rtl/core/sliding_window_statistics.sv =====
`timescale 1ns / 1ps
// Sliding window statistics top level: cell row, divider, square root, control.
// Depends on sws_pkg, sws_cell, sws_div, sws_sqrt.
//
// Usage: one signed Q8.8 sample per request on the in_ channel (valid/ready),
// one result per request on the out_ channel (min, mean, max, median,
// standard deviation, status). Configuration writes via cfg_we/cfg_index/
// cfg_data take effect at once; the user must make them only while the block
// is idle, which the block itself does not enforce. For windows of two or
// more, the request passes the cell row load, scan and sort, the bit-serial
// divider (run twice) and the square root before the final step. Windows of
// zero or one go straight to the final step. The block is ready for the next
// request in the same cycle in which the result appears.
// One request is worked at a time; in_ready is high only when the block is
// idle, also while a finished result waits in the output register.
// When the receiver stalls, the result holds in the output register and the
// next result waits in its final step until the register frees.
// Reset (synchronous, active low) clears the sample count, first sample,
// control state and registers to their defaults; no clearing pass is needed.
module sliding_window_statistics #(
  parameter int MAX_WINDOW = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [sws_pkg::SAMPLE_WIDTH-1:0] in_sample_value,
  input  logic                          in_start_of_stream,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [sws_pkg::SAMPLE_WIDTH-1:0] out_window_min,
  output logic signed [sws_pkg::SAMPLE_WIDTH-1:0] out_window_mean,
  output logic signed [sws_pkg::SAMPLE_WIDTH-1:0] out_window_max,
  output logic signed [sws_pkg::SAMPLE_WIDTH-1:0] out_window_median,
  output logic [sws_pkg::SAMPLE_WIDTH-1:0]        out_window_std_dev,
  output logic [1:0]                    out_status,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [sws_pkg::CFG_WIDTH-1:0] cfg_data
);
  import sws_pkg::*;

  localparam int N    = MAX_WINDOW;
  localparam int SW   = SAMPLE_WIDTH;
  localparam int CW   = $clog2(N + 1);
  localparam int SUMW = SW + CW;
  localparam int SQW  = 2 * SW + CW;
  localparam int PW   = 2 * SUMW;
  localparam int DVW  = 2 * CW;
  localparam int HW   = PW / 2;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOAD = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_ACC  = 4'd3;
  localparam logic [3:0] S_SQR  = 4'd4;
  localparam logic [3:0] S_SORT = 4'd5;
  localparam logic [3:0] S_MED  = 4'd6;
  localparam logic [3:0] S_DIVM = 4'd7;
  localparam logic [3:0] S_DIVS = 4'd8;
  localparam logic [3:0] S_SQRT = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  logic [3:0]  state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [5:0]  wlen_r;
  logic [15:0] slen_r;
  logic [15:0] count_r, count_nxt;
  sample_t     first_r;
  logic [CW-1:0] w_eff, w_r, real_r, real_nxt, half;
  logic [1:0]  status_r, status_nxt;
  logic        zero_r;
  logic        in_acc;

  sws_ctl_t    ctl;
  sample_t     store_w [N];
  key_t        key_w [N];

  logic        pad;
  sample_t     val;
  logic signed [SUMW-1:0] sum_r;
  sample_t     min_r, max_r, lo_r, hi_r, mean_r;
  logic signed [2*SW-1:0] sq_r;
  logic        sq_v_r;
  logic [SQW-1:0] sumsq_r;
  logic signed [PW-1:0] sum_sq;
  logic [PW-1:0] sum2_r, wsq_r, pair_r;
  logic [DVW-1:0] wwm1_r;
  logic [SUMW-1:0] mag;

  logic          div_start, div_done;
  logic [PW-1:0] div_num, div_quot;
  logic [DVW-1:0] div_den;
  logic          sq_start, sq_done;
  logic [HW-1:0] sq_root;
  logic [SW-1:0] sd_r;
  logic signed [SW:0] med_sum;
  sample_t       med;
  sample_t       qtrunc;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  assign w_eff = (int'(wlen_r) > N) ? CW'(N) : CW'(wlen_r);
  assign half  = {1'b0, w_r[CW-1:1]};

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= 6'd4;
      slen_r <= 16'hFFFF;
    end else if (cfg_we) begin
      unique case (cfg_index[0])
        REG_WINDOW_LENGTH: wlen_r <= cfg_data[5:0];
        REG_STREAM_LENGTH: slen_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // stream bookkeeping at accept
  always_comb begin
    if (in_start_of_stream || count_r == 16'd0) begin
      count_nxt = 16'd1;
    end else if (count_r != 16'hFFFF) begin
      count_nxt = count_r + 16'd1;
    end else begin
      count_nxt = count_r;
    end
    real_nxt = (count_nxt < 16'(w_eff)) ? CW'(count_nxt) : w_eff;
    if (w_eff == '0) begin
      status_nxt = ST_ZERO;
    end else if (w_eff == CW'(1)) begin
      status_nxt = ST_ONE;
    end else if (16'(w_eff) >= slen_r) begin
      status_nxt = ST_LONG_WINDOW;
    end else begin
      status_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      first_r <= '0;
    end else if (in_acc) begin
      count_r <= count_nxt;
      if (in_start_of_stream || count_r == 16'd0) begin
        first_r <= in_sample_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      w_r      <= w_eff;
      real_r   <= real_nxt;
      status_r <= status_nxt;
      zero_r   <= (w_eff < CW'(2));
    end
  end

  // cell row
  always_comb begin
    ctl.push  = in_acc;
    ctl.phase = cnt_r[0];
    case (state_r)
      S_LOAD:         ctl.op = OP_LOAD;
      S_SCAN, S_MED:  ctl.op = OP_ROTATE;
      S_SORT:         ctl.op = OP_SORT;
      default:        ctl.op = OP_HOLD;
    endcase
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    sws_cell #(
      .IDX(i),
      .N  (N),
      .CW (CW)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .win_len     (w_r),
      .real_len    (real_r),
      .first_sample(first_r),
      .store_in    ((i == 0) ? in_sample_value : store_w[(i + N - 1) % N]),
      .store_out   (store_w[i]),
      .key_left    (key_w[(i + N - 1) % N]),
      .key_right   (key_w[(i + 1) % N]),
      .key_out     (key_w[i])
    );
  end

  assign pad = key_w[0][SW];
  assign val = {~key_w[0][SW-1], key_w[0][SW-2:0]};

  // control
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_acc) begin
          state_nxt = (w_eff < CW'(2)) ? S_FIN : S_LOAD;
        end
      end
      S_LOAD: state_nxt = S_SCAN;
      S_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(N - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_ACC;
        end
      end
      S_ACC: state_nxt = S_SQR;
      S_SQR: state_nxt = S_SORT;
      S_SORT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(N - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_MED;
        end
      end
      S_MED: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == half) begin
          state_nxt = S_DIVM;
        end
      end
      S_DIVM: if (div_done) state_nxt = S_DIVS;
      S_DIVS: if (div_done) state_nxt = S_SQRT;
      S_SQRT: if (sq_done) state_nxt = S_FIN;
      S_FIN: if (!out_valid || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // scan accumulators
  assign sum_sq = sum_r * sum_r;
  assign mag    = sum_r[SUMW-1] ? SUMW'(-sum_r) : SUMW'(sum_r);

  always_ff @(posedge clk) begin
    if (state_r == S_LOAD) begin
      sum_r   <= '0;
      sumsq_r <= '0;
      min_r   <= {1'b0, {(SW-1){1'b1}}};
      max_r   <= {1'b1, {(SW-1){1'b0}}};
    end else begin
      if (state_r == S_SCAN && !pad) begin
        sum_r <= sum_r + SUMW'(val);
        if (val < min_r) min_r <= val;
        if (val > max_r) max_r <= val;
      end
      if (sq_v_r) begin
        sumsq_r <= sumsq_r + SQW'($unsigned(sq_r));
      end
    end
    sq_r   <= val * val;
    sq_v_r <= (state_r == S_SCAN) && !pad;
    if (state_r == S_SQR) begin
      sum2_r <= $unsigned(sum_sq);
      wsq_r  <= PW'(w_r) * PW'(sumsq_r);
      wwm1_r <= DVW'(w_r) * DVW'(w_r - 1'b1);
    end
    if (state_r == S_SORT) begin
      pair_r <= wsq_r - sum2_r;
    end
    if (state_r == S_MED) begin
      if (cnt_r == half - 1'b1) lo_r <= val;
      if (cnt_r == half)        hi_r <= val;
    end
  end

  // divider and square root
  assign div_start = (state_r == S_MED && cnt_r == half) || (state_r == S_DIVM && div_done);
  assign div_num   = (state_r == S_MED) ? PW'(mag) : pair_r;
  assign div_den   = (state_r == S_MED) ? DVW'(w_r) : wwm1_r;

  sws_div #(
    .NW(PW),
    .DW(DVW)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_quot)
  );

  assign sq_start = (state_r == S_DIVS) && div_done;

  sws_sqrt #(
    .RW(PW)
  ) u_sqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .start(sq_start),
    .rad  (div_quot),
    .done (sq_done),
    .root (sq_root)
  );

  assign qtrunc = div_quot[SW-1:0];

  always_ff @(posedge clk) begin
    if (state_r == S_DIVM && div_done) begin
      mean_r <= sum_r[SUMW-1] ? -qtrunc : qtrunc;
    end
    if (sq_done) begin
      sd_r <= (|sq_root[HW-1:SW]) ? {SW{1'b1}} : sq_root[SW-1:0];
    end
  end

  assign med_sum = {lo_r[SW-1], lo_r} + {hi_r[SW-1], hi_r};
  assign med     = w_r[0] ? hi_r : med_sum[SW:1];

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (state_r == S_FIN && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && (!out_valid || out_ready)) begin
      out_status         <= status_r;
      out_window_min     <= zero_r ? '0 : min_r;
      out_window_mean    <= zero_r ? '0 : mean_r;
      out_window_max     <= zero_r ? '0 : max_r;
      out_window_median  <= zero_r ? '0 : med;
      out_window_std_dev <= zero_r ? '0 : sd_r;
    end
  end

endmodule

// ===== rtl/core/sws_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for sliding_window_statistics, attached by bind.
// Depends on sws_pkg.
module sws_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [sws_pkg::SAMPLE_WIDTH-1:0] out_window_min,
  input logic signed [sws_pkg::SAMPLE_WIDTH-1:0] out_window_max,
  input logic signed [sws_pkg::SAMPLE_WIDTH-1:0] out_window_median,
  input logic [sws_pkg::SAMPLE_WIDTH-1:0]        out_window_std_dev,
  input logic [1:0]                    out_status
);
  import sws_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_window_median))
    else $error("result dropped or changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_ZERO || out_status == ST_ONE) |->
      out_window_min == '0 && out_window_max == '0 && out_window_std_dev == '0)
    else $error("degenerate window with nonzero result");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OK || out_status == ST_LONG_WINDOW) |->
      out_window_min <= out_window_median && out_window_median <= out_window_max)
    else $error("median outside min and max");

endmodule

bind sliding_window_statistics sws_checker u_sws_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_window_min    (out_window_min),
  .out_window_max    (out_window_max),
  .out_window_median (out_window_median),
  .out_window_std_dev(out_window_std_dev),
  .out_status        (out_status)
);

// ===== sim/tb_sliding_window_statistics.sv =====
`timescale 1ns / 1ps
// Testbench for sliding_window_statistics: directed table then random samples,
// each result checked against an in-bench window statistics predictor or a typed-in expectation.
// Depends on sws_pkg and the sliding_window_statistics RTL.
module tb_sliding_window_statistics;
  import sws_pkg::*;

  typedef struct {
    sample_t     mn;
    sample_t     mean;
    sample_t     mx;
    sample_t     med;
    logic [15:0] sd;
    logic [1:0]  st;
  } stats_t;

  typedef struct {
    bit          is_cfg;
    logic        reg_idx;
    logic [15:0] reg_val;
    sample_t     smp;
    bit          sos;
    bit          typed;
    stats_t      res;
  } row_t;

  typedef struct {
    bit     typed;
    stats_t res;
  } hint_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  sample_t     in_sample_value = '0;
  logic        in_start_of_stream = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  sample_t     out_window_min, out_window_mean, out_window_max, out_window_median;
  logic [15:0] out_window_std_dev;
  logic [1:0]  out_status;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  sliding_window_statistics uut (.*);

  always #4 clk = ~clk;

  // predictor state
  sample_t     hist [32];
  sample_t     first_smp;
  int          smp_count;
  logic [5:0]  win_len;
  logic [15:0] strm_len;

  stats_t      stats_due [$];
  hint_t       hints [$];
  row_t        dir_rows [$];
  int          send_idle_pct, recv_idle_pct;
  int          n_errors, n_checked, n_requests, n_cfg_writes;

  function automatic longint floor_root(longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic stats_t window_stats(sample_t x, bit sos);
    stats_t o;
    longint v [32];
    longint t, sum, pairs, d, sd, s;
    int w, fill;
    o = '{default: '0};
    if (sos || smp_count == 0) begin
      first_smp = x;
      smp_count = 0;
    end
    for (int i = 31; i > 0; i--) hist[i] = hist[i-1];
    hist[0] = x;
    if (smp_count < 65535) smp_count++;
    w = (win_len > 32) ? 32 : win_len;
    if (w == 0) begin
      o.st = ST_ZERO;
      return o;
    end
    if (w == 1) begin
      o.st = ST_ONE;
      return o;
    end
    o.st = (w >= strm_len) ? ST_LONG_WINDOW : ST_OK;
    fill = (smp_count < w) ? smp_count : w;
    sum = 0;
    for (int i = 0; i < w; i++) begin
      v[i] = (i < fill) ? longint'(hist[i]) : longint'(first_smp);
      sum += v[i];
    end
    pairs = 0;
    for (int i = 0; i < w; i++)
      for (int j = i + 1; j < w; j++) begin
        d = v[i] - v[j];
        pairs += d * d;
      end
    sd = floor_root(pairs / (w * (w - 1)));
    if (sd > 65535) sd = 65535;
    for (int i = 1; i < w; i++) begin
      t = v[i];
      for (int j = i; j > 0 && v[j-1] > t; j--) begin
        v[j] = v[j-1];
        v[j-1] = t;
      end
    end
    o.mn   = sample_t'(v[0]);
    o.mx   = sample_t'(v[w-1]);
    o.mean = sample_t'(sum / w);
    if (w % 2 == 0) begin
      s = v[w/2-1] + v[w/2];
      o.med = sample_t'(s >>> 1);
    end else begin
      o.med = sample_t'(v[w/2]);
    end
    o.sd = sd[15:0];
    return o;
  endfunction

  // request acceptance: predict, or take the typed-in expectation
  always @(posedge clk) begin
    stats_t p;
    hint_t h;
    if (rst_n && in_valid && in_ready) begin
      p = window_stats(in_sample_value, in_start_of_stream);
      h = hints.pop_front();
      stats_due.push_back(h.typed ? h.res : p);
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    stats_t e;
    if (rst_n && out_valid && out_ready) begin
      n_checked++;
      if (stats_due.size() == 0) begin
        $error("result with nothing expected");
        n_errors++;
      end else begin
        e = stats_due.pop_front();
        if (out_window_min !== e.mn) begin
          $error("window_min exp %0d got %0d", e.mn, out_window_min); n_errors++;
        end
        if (out_window_mean !== e.mean) begin
          $error("window_mean exp %0d got %0d", e.mean, out_window_mean); n_errors++;
        end
        if (out_window_max !== e.mx) begin
          $error("window_max exp %0d got %0d", e.mx, out_window_max); n_errors++;
        end
        if (out_window_median !== e.med) begin
          $error("window_median exp %0d got %0d", e.med, out_window_median); n_errors++;
        end
        if (out_window_std_dev !== e.sd) begin
          $error("window_std_dev exp %0d got %0d", e.sd, out_window_std_dev); n_errors++;
        end
        if (out_status !== e.st) begin
          $error("status exp %0d got %0d", e.st, out_status); n_errors++;
        end
      end
    end
  end

  task automatic send_request(sample_t s, bit sos, bit typed, stats_t r);
    bit rdy;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    hints.push_back('{typed, r});
    in_valid <= 1'b1;
    in_sample_value <= s;
    in_start_of_stream <= sos;
    n_requests++;
    forever begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
      if (rdy) break;
    end
  endtask

  task automatic drain(int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (stats_due.size() != 0 || hints.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_WINDOW_LENGTH) win_len = val[5:0];
    else strm_len = val;
    n_cfg_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void add_item(sample_t s, bit sos);
    dir_rows.push_back('{0, 0, 0, s, sos, 0, '{default: '0}});
  endfunction

  function automatic void add_typed(sample_t s, bit sos, stats_t r);
    dir_rows.push_back('{0, 0, 0, s, sos, 1, r});
  endfunction

  function automatic void add_cfg(logic idx, logic [15:0] val);
    dir_rows.push_back('{1, idx, val, 0, 0, 0, '{default: '0}});
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(9))
      0: return sample_t'(16'h8000);
      1: return sample_t'(16'h7fff);
      2: return sample_t'($urandom_range(8) - 4);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_window();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd32;
      3: return 16'($urandom_range(63, 33));
      default: return 16'($urandom_range(31, 2));
    endcase
  endfunction

  function automatic logic [15:0] rand_stream();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'hffff;
      2: return 16'($urandom_range(40, 1));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    row_t rw;
    stats_t none;
    none = '{default: '0};
    for (int i = 0; i < 32; i++) hist[i] = '0;
    first_smp = '0; smp_count = 0; win_len = 6'd4; strm_len = 16'hffff;
    send_idle_pct = 0; recv_idle_pct = 0;
    n_errors = 0; n_checked = 0; n_requests = 0; n_cfg_writes = 0;

    add_typed(16'sh0100, 1, '{16'sh0100, 16'sh0100, 16'sh0100, 16'sh0100, 0, ST_OK});
    add_item(16'sh8000, 0);
    add_item(16'sh7fff, 0);
    add_item(-16'sd1, 0);
    add_item(16'sd5, 0);
    add_cfg(REG_WINDOW_LENGTH, 16'd0);
    add_typed(16'sh1234, 0, '{0, 0, 0, 0, 0, ST_ZERO});
    add_cfg(REG_WINDOW_LENGTH, 16'd1);
    add_typed(16'sh8000, 1, '{0, 0, 0, 0, 0, ST_ONE});
    add_cfg(REG_WINDOW_LENGTH, 16'd63);
    add_typed(16'sh7fff, 1, '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0, ST_OK});
    add_item(16'sh8000, 0);
    add_item(16'sh8000, 0);
    add_cfg(REG_STREAM_LENGTH, 16'd5);
    add_cfg(REG_WINDOW_LENGTH, 16'd5);
    add_item(16'sd300, 1);
    add_item(-16'sd301, 0);
    add_cfg(REG_STREAM_LENGTH, 16'd0);
    add_cfg(REG_WINDOW_LENGTH, 16'd2);
    add_item(-16'sd3, 1);
    add_item(16'sd0, 0);
    add_item(16'sh7fff, 0);
    add_cfg(REG_STREAM_LENGTH, 16'hffff);
    add_cfg(REG_WINDOW_LENGTH, 16'd32);
    add_item(16'shffff, 1);
    add_item(16'sh5555, 0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      rw = dir_rows[i];
      if (rw.is_cfg) begin
        drain(4);
        write_reg(rw.reg_idx, rw.reg_val);
      end else begin
        send_request(rw.smp, rw.sos, rw.typed, rw.res);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 50 : 0;
      recv_idle_pct = (ph == 0) ? 50 : (ph == 1) ? 38 : 0;
      for (int k = 0; k < 280; k++) begin
        if (k % 40 == 0) begin
          drain(4);
          write_reg(REG_WINDOW_LENGTH, rand_window());
          if ($urandom_range(1)) write_reg(REG_STREAM_LENGTH, rand_stream());
        end
        if (ph == 1 && k == 130) drain(0);
        send_request(rand_sample(), ($urandom_range(99) < 4), 0, none);
      end
    end

    drain(250);
    $display("Sent %0d samples with %0d register writes; checked %0d results.",
             n_requests, n_cfg_writes, n_checked);
    $display("Covered zero, one, long and over-stream windows and stream restarts.");
    if (n_errors == 0 && stats_due.size() == 0)
      $display("tb_sliding_window_statistics: clean");
    else
      $display("tb_sliding_window_statistics: errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout after %0d results", n_checked);
    $display("tb_sliding_window_statistics: errors");
    $finish;
  end

endmodule
